/* hdl/ltcd_pkg.sv */
// Package for the loop trip-count detector: payload structs, commands,
// controller states, configuration indexes and defaults. No dependencies.
package ltcd_pkg;

	localparam int PC_W = 48;
	localparam int TRIP_W = 16;
	localparam int CFG_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int TABLE_SIZE_DEF = 32;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_AGING_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_CONF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_AGE = 2'd2;

	localparam logic [7:0] AGING_PERIOD_RST = 8'd128;
	localparam logic signed [2:0] NEW_CONF_RST = 3'sd0;
	localparam logic [1:0] NEW_AGE_RST = 2'd3;
	localparam logic [1:0] AGE_HIT = 2'd3;
	localparam logic signed [2:0] CONF_MAX = 3'sd3;
	localparam logic signed [2:0] CONF_MIN = -3'sd4;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_UPDATE = 2'd2;

	typedef struct packed {
		logic [PC_W-1:0] branch_pc;
		logic [PC_W-1:0] target_pc;
		logic [PC_W-1:0] fall_thru_pc;
		logic [PC_W-1:0] forward_taken_pc;
	} ltcd_in_t;

	typedef struct packed {
		logic [1:0] command;
		logic [PC_W-1:0] loop_pc;
		logic [PC_W-1:0] loop_target;
		logic [PC_W-1:0] loop_exit_target;
		logic [PC_W-1:0] loop_fall_thru;
		logic [TRIP_W-1:0] loop_trip;
		logic has_intra_taken;
	} ltcd_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} ltcd_state_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic apply;
	} ltcd_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic scan_done;
	} ltcd_stat_t;

endpackage

/* hdl/ltcd_ctrl.sv */
// Controller of the loop trip-count detector: sequences load, table scan
// and update. Depends on ltcd_pkg.
module ltcd_ctrl import ltcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  ltcd_stat_t stat,
	output ltcd_cmd_t  cmd
);

	ltcd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hdl/ltcd_dp.sv */
// Datapath of the loop trip-count detector: slot table, aging, scan for
// hit and victim, entry update and result register. Depends on ltcd_pkg.
module ltcd_dp import ltcd_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ltcd_in_t             in_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	input  ltcd_cmd_t            cmd,
	output ltcd_stat_t           stat,
	output logic                 done,
	output ltcd_out_t            result
);

	localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [7:0] aging_period_q, aging_tick_q;
	logic signed [2:0] new_conf_q;
	logic [1:0] new_age_q;

	logic [TABLE_SIZE-1:0] used_q;
	logic                  valid_q [TABLE_SIZE];
	logic [PC_W-1:0]       branch_q [TABLE_SIZE];
	logic [PC_W-1:0]       target_q [TABLE_SIZE];
	logic [PC_W-1:0]       exit_q [TABLE_SIZE];
	logic                  exit_seen_q [TABLE_SIZE];
	logic [PC_W-1:0]       fall_q [TABLE_SIZE];
	logic [COUNT_BITS-1:0] run_q [TABLE_SIZE];
	logic [COUNT_BITS-1:0] trip_q [TABLE_SIZE];
	logic signed [2:0]     conf_q [TABLE_SIZE];
	logic [1:0]            age_q [TABLE_SIZE];
	logic                  intra_q [TABLE_SIZE];

	ltcd_in_t item_q;
	logic [CW-1:0] idx_q;
	logic hit_q, free_q, vic_ok_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, vic_idx_q;
	logic done_q;
	ltcd_out_t result_q;

	logic [IW-1:0] idx;
	assign idx = idx_q[IW-1:0];
	assign stat.scan_done = (idx_q == CW'(TABLE_SIZE - 1));

	// Age of the slot under scan, already decayed by this transaction's sweep.
	logic [1:0] scan_age, vic_age;
	logic age_tick;
	logic [7:0] tick_inc;
	assign tick_inc = aging_tick_q + 8'd1;
	assign age_tick = (tick_inc >= aging_period_q);
	always_comb begin
		scan_age = age_q[idx];
		vic_age = age_q[vic_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aging_period_q <= AGING_PERIOD_RST;
			new_conf_q <= NEW_CONF_RST;
			new_age_q <= NEW_AGE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_AGING_PERIOD: aging_period_q <= cfg_data;
				CFG_NEW_CONF: new_conf_q <= cfg_data[2:0];
				CFG_NEW_AGE: new_age_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Scan: one slot per cycle for the first hit, first free slot and the
	// victim (lowest age, then lowest branch address). Ages are decayed on
	// load when the aging tick fires, so the scan sees this transaction's values.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			idx_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			vic_ok_q <= 1'b0;
		end else if (cmd.scan) begin
			idx_q <= idx_q + CW'(1);
			if (used_q[idx]) begin
				if (!hit_q && branch_q[idx] == item_q.branch_pc) begin
					hit_q <= 1'b1;
					hit_idx_q <= idx;
				end
				if (!vic_ok_q || scan_age < vic_age
						|| (scan_age == vic_age && branch_q[idx] < branch_q[vic_idx_q])) begin
					vic_ok_q <= 1'b1;
					vic_idx_q <= idx;
				end
			end else if (!free_q) begin
				free_q <= 1'b1;
				free_idx_q <= idx;
			end
		end
	end

	logic backward;
	logic [IW-1:0] s, v;
	logic signed [2:0] conf_n;
	logic mism_b, mism_f, intra_n;
	ltcd_out_t res_d;
	always_comb begin
		backward = item_q.target_pc < item_q.branch_pc;
		s = hit_idx_q;
		v = free_q ? free_idx_q : vic_idx_q;
		mism_b = item_q.target_pc != target_q[s];
		mism_f = exit_seen_q[s] && item_q.target_pc != exit_q[s];
		conf_n = conf_q[s];
		if (trip_q[s] != run_q[s]) begin
			if (conf_q[s] > CONF_MIN) conf_n = conf_q[s] - 3'sd1;
		end else if (conf_q[s] < CONF_MAX) begin
			conf_n = conf_q[s] + 3'sd1;
		end
		intra_n = (target_q[s] < item_q.forward_taken_pc)
			&& (branch_q[s] > item_q.forward_taken_pc);
		res_d = '0;
		if (hit_q && valid_q[s]) begin
			if (backward && mism_b || !backward && mism_f) begin
				res_d.command = CMD_DELETE;
				res_d.loop_pc = item_q.branch_pc;
			end else if (!backward) begin
				res_d.loop_pc = item_q.branch_pc;
				if (conf_n < -3'sd3) begin
					res_d.command = CMD_DELETE;
				end else begin
					res_d.command = CMD_UPDATE;
					res_d.loop_target = target_q[s];
					res_d.loop_exit_target = item_q.target_pc;
					res_d.loop_fall_thru = fall_q[s];
					res_d.loop_trip = TRIP_W'(run_q[s]);
					res_d.has_intra_taken = intra_q[s] | intra_n;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			aging_tick_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.apply;
			if (cmd.load) begin
				aging_tick_q <= age_tick ? 8'd0 : tick_inc;
			end
			if (cmd.apply && !hit_q && backward) used_q[v] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && age_tick) begin
			for (int i = 0; i < TABLE_SIZE; i++)
				if (used_q[i] && age_q[i] != 2'd0) age_q[i] <= age_q[i] - 2'd1;
		end
		if (cmd.apply) begin
			result_q <= res_d;
			if (!hit_q) begin
				if (backward) begin
					valid_q[v] <= 1'b1;
					branch_q[v] <= item_q.branch_pc;
					target_q[v] <= item_q.target_pc;
					exit_q[v] <= '0;
					exit_seen_q[v] <= 1'b0;
					fall_q[v] <= item_q.fall_thru_pc;
					run_q[v] <= COUNT_BITS'(1);
					trip_q[v] <= '0;
					conf_q[v] <= new_conf_q;
					age_q[v] <= new_age_q;
					intra_q[v] <= 1'b0;
				end
			end else begin
				age_q[s] <= AGE_HIT;
				if (valid_q[s]) begin
					if (backward && mism_b || !backward && mism_f) begin
						valid_q[s] <= 1'b0;
					end else begin
						if (intra_n) intra_q[s] <= 1'b1;
						if (backward) begin
							if (run_q[s] != CNT_MAX) run_q[s] <= run_q[s] + COUNT_BITS'(1);
						end else begin
							conf_q[s] <= conf_n;
							trip_q[s] <= run_q[s];
							run_q[s] <= '0;
							exit_q[s] <= item_q.target_pc;
							exit_seen_q[s] <= 1'b1;
							if (conf_n < -3'sd3) valid_q[s] <= 1'b0;
						end
					end
				end
			end
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

/* hdl/loop_trip_count_detector.sv */
// Top level of the loop trip-count detector: joins controller and datapath.
// Depends on ltcd_pkg, ltcd_ctrl and ltcd_dp.
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------
//  input    | start & !busy    | in_item (ltcd_in_t)
//  result   | done (one cycle) | result (ltcd_out_t)
//  config   | cfg_we           | cfg_idx, cfg_data
//
// A transaction runs from acceptance to result through a load step, a scan
// of one table slot per cycle for the hit and victim, and an update step;
// the result strobe follows. The slot scan sets the rate.
// Reset clears the occupancy map and the aging tick; the result cannot stall.
module loop_trip_count_detector import ltcd_pkg::*; #(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ltcd_in_t             in_item,
	output logic                 done,
	output ltcd_out_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	ltcd_cmd_t cmd;
	ltcd_stat_t stat;

	ltcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
	);

	ltcd_dp #(.TABLE_SIZE(TABLE_SIZE), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cfg_we(cfg_we),
		.cfg_idx(cfg_idx), .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
		.done(done), .result(result)
	);

endmodule

/* tb/tb_loop_trip_count_detector.sv */
// Self-checking testbench for loop_trip_count_detector: a scoreboard class
// predicts each result from the accepted branch transactions. Depends on ltcd_pkg and loop_trip_count_detector.
`timescale 1ns / 100ps

module tb_loop_trip_count_detector import ltcd_pkg::*;;

	localparam int SLOTS = 32;
	localparam int N_LOOPS = 40;
	localparam int LATENCY = SLOTS + 8;
	localparam logic [15:0] RUN_SAT = 16'hFFFF;

	class trip_scoreboard;
		bit used[SLOTS];
		bit valid[SLOTS];
		bit exit_seen[SLOTS];
		bit intra[SLOTS];
		logic [PC_W-1:0] branch[SLOTS];
		logic [PC_W-1:0] target[SLOTS];
		logic [PC_W-1:0] exit_tgt[SLOTS];
		logic [PC_W-1:0] fall_thru[SLOTS];
		logic [15:0] run_count[SLOTS];
		logic [15:0] trip_count[SLOTS];
		int conf[SLOTS];
		logic [1:0] age[SLOTS];
		logic [7:0] tick;
		logic [7:0] period;
		int new_conf;
		logic [1:0] new_age;
		ltcd_out_t pending[$];
		int errors;

		function new();
			foreach (used[i]) used[i] = 0;
			tick = 0;
			period = AGING_PERIOD_RST;
			new_conf = 0;
			new_age = NEW_AGE_RST;
			errors = 0;
		endfunction

		function void set_config(logic [7:0] p, int c, logic [1:0] a);
			period = p;
			new_conf = c;
			new_age = a;
		endfunction

		function int pick_victim();
			int best;
			best = -1;
			for (int i = 0; i < SLOTS; i++)
				if (!used[i])
					return i;
			for (int i = 0; i < SLOTS; i++)
				if (best < 0 || age[i] < age[best] ||
						(age[i] == age[best] && branch[i] < branch[best]))
					best = i;
			return best;
		endfunction

		function void note_branch(ltcd_in_t it);
			ltcd_out_t o;
			int s;
			int v;
			bit bkw;
			bit dropped;
			o = '0;
			s = -1;
			dropped = 0;
			bkw = it.target_pc < it.branch_pc;
			tick = tick + 8'd1;
			if (tick >= period) begin
				for (int i = 0; i < SLOTS; i++)
					if (used[i] && age[i] > 0)
						age[i] = age[i] - 2'd1;
				tick = 0;
			end
			for (int i = 0; i < SLOTS; i++)
				if (s < 0 && used[i] && branch[i] == it.branch_pc)
					s = i;
			if (s < 0) begin
				if (bkw) begin
					v = pick_victim();
					used[v] = 1;
					valid[v] = 1;
					branch[v] = it.branch_pc;
					target[v] = it.target_pc;
					exit_tgt[v] = '0;
					exit_seen[v] = 0;
					fall_thru[v] = it.fall_thru_pc;
					run_count[v] = 16'd1;
					trip_count[v] = 16'd0;
					conf[v] = new_conf;
					age[v] = new_age;
					intra[v] = 0;
				end
			end else begin
				age[s] = AGE_HIT;
				if (valid[s]) begin
					if (bkw && it.target_pc != target[s]) begin
						valid[s] = 0;
						dropped = 1;
					end else if (!bkw && exit_seen[s] && it.target_pc != exit_tgt[s]) begin
						valid[s] = 0;
						dropped = 1;
					end else begin
						if (bkw) begin
							if (run_count[s] != RUN_SAT)
								run_count[s] = run_count[s] + 16'd1;
						end else begin
							if (trip_count[s] != run_count[s]) begin
								if (conf[s] > -4)
									conf[s]--;
							end else if (conf[s] < 3) begin
								conf[s]++;
							end
							if (conf[s] < -3) begin
								valid[s] = 0;
								dropped = 1;
							end
							trip_count[s] = run_count[s];
							run_count[s] = 0;
							exit_tgt[s] = it.target_pc;
							exit_seen[s] = 1;
						end
						if (target[s] < it.forward_taken_pc && branch[s] > it.forward_taken_pc)
							intra[s] = 1;
						if (!dropped && !bkw) begin
							o.command = CMD_UPDATE;
							o.loop_pc = it.branch_pc;
							o.loop_target = target[s];
							o.loop_exit_target = exit_tgt[s];
							o.loop_fall_thru = fall_thru[s];
							o.loop_trip = trip_count[s];
							o.has_intra_taken = intra[s];
						end
					end
					if (dropped) begin
						o.command = CMD_DELETE;
						o.loop_pc = it.branch_pc;
					end
				end
			end
			pending.insert(pending.size(), o);
		endfunction

		function void cmp_field(string name, logic [PC_W-1:0] e, logic [PC_W-1:0] a);
			if (e !== a) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(ltcd_out_t r);
			ltcd_out_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, r);
				errors++;
				return;
			end
			e = pending[0];
			pending.delete(0);
			cmp_field("command", e.command, r.command);
			cmp_field("loop_pc", e.loop_pc, r.loop_pc);
			cmp_field("loop_target", e.loop_target, r.loop_target);
			cmp_field("loop_exit_target", e.loop_exit_target, r.loop_exit_target);
			cmp_field("loop_fall_thru", e.loop_fall_thru, r.loop_fall_thru);
			cmp_field("loop_trip", e.loop_trip, r.loop_trip);
			cmp_field("has_intra_taken", e.has_intra_taken, r.has_intra_taken);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ltcd_in_t in_item;
	logic done;
	ltcd_out_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;

	trip_scoreboard sb;
	int gap_pct;
	int sent;
	logic [PC_W-1:0] lp_br[N_LOOPS];
	logic [PC_W-1:0] lp_tg[N_LOOPS];
	logic [PC_W-1:0] lp_exit[N_LOOPS];
	logic [PC_W-1:0] lp_ft[N_LOOPS];
	int lp_trip[N_LOOPS];

	loop_trip_count_detector u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#20ms;
		$display("tb_loop_trip_count_detector: done, errors");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_branch(in_item);
			if (done)
				sb.check_result(result);
		end
	end

	function automatic logic [PC_W-1:0] rand_pc();
		return {16'($urandom()), 32'($urandom())};
	endfunction

	// Called at a rising edge; returns at the edge where the transaction is taken.
	task automatic send_branch(logic [PC_W-1:0] br, logic [PC_W-1:0] tg,
			logic [PC_W-1:0] ft, logic [PC_W-1:0] fw);
		int n;
		if ($urandom_range(0, 99) < gap_pct) begin
			n = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
		start <= 1'b1;
		in_item <= '{branch_pc: br, target_pc: tg, fall_thru_pc: ft, forward_taken_pc: fw};
		forever begin
			@(negedge clk);
			if (!busy)
				break;
		end
		@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_config(logic [7:0] p, int c, logic [1:0] a);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_AGING_PERIOD;
		cfg_data <= p;
		@(posedge clk);
		cfg_idx <= CFG_NEW_CONF;
		cfg_data <= 8'(3'(c));
		@(posedge clk);
		cfg_idx <= CFG_NEW_AGE;
		cfg_data <= {6'd0, a};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(p, c, a);
		@(posedge clk);
	endtask

	// One pass through loop k: backward iterations then an exit.
	task automatic run_loop(int k);
		int iters;
		logic [PC_W-1:0] fw;
		logic [PC_W-1:0] xt;
		iters = ($urandom_range(0, 9) < 8) ? lp_trip[k] : $urandom_range(0, 8);
		for (int j = 0; j < iters; j++) begin
			fw = ($urandom_range(0, 1) != 0) ? lp_tg[k] + $urandom_range(1, 15) : rand_pc();
			send_branch(lp_br[k], lp_tg[k], lp_ft[k], fw);
		end
		xt = ($urandom_range(0, 19) != 0) ? lp_exit[k] : lp_br[k] + $urandom_range(1, 99);
		fw = ($urandom_range(0, 1) != 0) ? lp_tg[k] + $urandom_range(1, 15) : rand_pc();
		send_branch(lp_br[k], xt, rand_pc(), fw);
	endtask

	task automatic random_phase(int target_items, bit pause_once);
		int k;
		int r;
		int stop_at;
		stop_at = sent + target_items;
		while (sent < stop_at) begin
			if (pause_once && sent > stop_at - target_items / 2) begin
				drain();
				pause_once = 0;
			end
			k = $urandom_range(0, N_LOOPS - 1);
			r = $urandom_range(0, 9);
			if (r < 8)
				run_loop(k);
			else if (r == 8)
				send_branch(lp_br[k], lp_tg[k] - $urandom_range(1, 4), rand_pc(), rand_pc());
			else
				send_branch(rand_pc(), rand_pc(), rand_pc(), rand_pc());
		end
	endtask

	initial begin
		logic [PC_W-1:0] pmax;
		int cnt;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_idx = CFG_AGING_PERIOD;
		cfg_data = '0;
		gap_pct = 0;
		sent = 0;
		pmax = '1;
		for (int k = 0; k < N_LOOPS; k++) begin
			lp_br[k] = rand_pc() | 48'h1000;
			lp_tg[k] = lp_br[k] - $urandom_range(16, 4000);
			lp_exit[k] = lp_br[k] + $urandom_range(1, 4000);
			lp_ft[k] = lp_br[k] + 4;
			lp_trip[k] = $urandom_range(1, 6);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset configuration.
		send_branch(pmax, '0, pmax, pmax);
		send_branch('0, pmax, '0, '0);
		send_branch(48'h5000, 48'h5000, 48'h5004, '0);
		send_branch(48'h1000, 48'h0800, 48'h1004, '0);
		send_branch(48'h1000, 48'h0800, '0, '0);
		send_branch(48'h1000, 48'h0800, '0, '0);
		send_branch(48'h1000, 48'h2000, '0, 48'h0900);
		repeat (3) send_branch(48'h1000, 48'h0800, '0, '0);
		send_branch(48'h1000, 48'h2000, '0, '0);
		// Exit to another target drops the entry; a later hit is ignored.
		send_branch(48'h1000, 48'h3000, '0, '0);
		send_branch(48'h1000, 48'h0800, '0, '0);
		send_branch(48'h7000, 48'h6000, '0, '0);
		send_branch(48'h7000, 48'h6800, '0, '0);
		// Alternating trip counts walk the confidence down until the entry drops.
		send_branch(48'h9000, 48'h8000, '0, '0);
		for (int e = 0; e < 4; e++) begin
			send_branch(48'h9000, 48'hA000, '0, 48'h8800);
			cnt = (e % 2 == 0) ? 3 : 1;
			if (e < 3)
				repeat (cnt) send_branch(48'h9000, 48'h8000, '0, '0);
		end
		drain();

		write_config(8'd1, -4, 2'd0);
		gap_pct = 10;
		random_phase(510, 0);
		drain();

		write_config(8'd255, 3, 2'd3);
		gap_pct = 75;
		random_phase(510, 1);
		drain();

		write_config(8'd0, -1, 2'd1);
		gap_pct = 0;
		random_phase(300, 0);
		drain();
		write_config(8'd7, $urandom_range(0, 7) - 4, 2'($urandom_range(0, 3)));
		random_phase(220, 0);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_loop_trip_count_detector: done, clean");
		else
			$display("tb_loop_trip_count_detector: done, errors");
		$finish;
	end

endmodule

/* files.f */
hdl/ltcd_pkg.sv
hdl/ltcd_ctrl.sv
hdl/ltcd_dp.sv
hdl/loop_trip_count_detector.sv
tb/tb_loop_trip_count_detector.sv
